@@ rtl/core/snps_pkg.sv @@
// Shared types and widths for the segment nearest point snap core.
// Used by every module under rtl/core; depends on nothing.
package snps_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int PROD_W  = 66;
	localparam int DOT_W   = 67;
	localparam int TOL_W   = 31;
	localparam int TOL2_W  = 62;
	localparam int DIST_W  = 33;
	localparam int RAD_W   = 72;
	localparam int ROOT_W  = 36;
	localparam int SQREM_W = 38;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 2;

	typedef logic [IDX_W-1:0] snps_idx_t;

	localparam snps_idx_t CFG_CURSOR_X  = 2'd0;
	localparam snps_idx_t CFG_CURSOR_Y  = 2'd1;
	localparam snps_idx_t CFG_TOLERANCE = 2'd2;

	typedef enum logic [1:0] {
		MODE_START,
		MODE_END,
		MODE_LERP
	} snps_mode_t;

	typedef struct packed {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [DIFF_W-1:0]  dx;
		logic [DIFF_W-1:0]  dy;
		snps_mode_t         mode;
	} snps_seg_t;

endpackage

@@ rtl/core/snps_div_stage.sv @@
// One restoring step of the projection divider: one quotient bit per stage.
// Depends on snps_pkg.
module snps_div_stage #(
	parameter int T_FRAC_BITS = 32,
	parameter int TAG_BITS    = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_i,
	input  logic [TAG_BITS-1:0]         tag_i,
	input  snps_pkg::snps_seg_t         seg_i,
	input  logic [snps_pkg::PROD_W-1:0] rem_i,
	input  logic [snps_pkg::PROD_W-1:0] len2_i,
	input  logic [T_FRAC_BITS-1:0]      t_i,
	output logic                        valid_o,
	output logic [TAG_BITS-1:0]         tag_o,
	output snps_pkg::snps_seg_t         seg_o,
	output logic [snps_pkg::PROD_W-1:0] rem_o,
	output logic [snps_pkg::PROD_W-1:0] len2_o,
	output logic [T_FRAC_BITS-1:0]      t_o
);

	logic [snps_pkg::PROD_W:0]   sh;
	logic [snps_pkg::PROD_W:0]   diff;
	logic                        ge;
	logic                        valid_s1;
	logic [TAG_BITS-1:0]         tag_s1;
	snps_pkg::snps_seg_t         seg_s1;
	logic [snps_pkg::PROD_W-1:0] rem_s1;
	logic [snps_pkg::PROD_W-1:0] len2_s1;
	logic [T_FRAC_BITS-1:0]      t_s1;

	always_comb begin
		sh   = {rem_i, 1'b0};
		diff = sh - {1'b0, len2_i};
		ge   = (sh >= {1'b0, len2_i});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= tag_i;
			seg_s1  <= seg_i;
			len2_s1 <= len2_i;
			rem_s1  <= ge ? diff[snps_pkg::PROD_W-1:0] : sh[snps_pkg::PROD_W-1:0];
			t_s1    <= {t_i[T_FRAC_BITS-2:0], ge};
		end
	end

	assign valid_o = valid_s1;
	assign tag_o   = tag_s1;
	assign seg_o   = seg_s1;
	assign rem_o   = rem_s1;
	assign len2_o  = len2_s1;
	assign t_o     = t_s1;

endmodule

@@ rtl/core/snps_sqrt_stage.sv @@
// One digit step of the distance square root: one root bit per stage.
// Depends on snps_pkg.
module snps_sqrt_stage #(
	parameter int TAG_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_i,
	input  logic [TAG_BITS-1:0]          tag_i,
	input  logic [snps_pkg::COORD_W-1:0] nx_i,
	input  logic [snps_pkg::COORD_W-1:0] ny_i,
	input  logic [snps_pkg::RAD_W-1:0]   rad_i,
	input  logic [snps_pkg::ROOT_W-1:0]  root_i,
	input  logic [snps_pkg::SQREM_W-1:0] rem_i,
	output logic                         valid_o,
	output logic [TAG_BITS-1:0]          tag_o,
	output logic [snps_pkg::COORD_W-1:0] nx_o,
	output logic [snps_pkg::COORD_W-1:0] ny_o,
	output logic [snps_pkg::RAD_W-1:0]   rad_o,
	output logic [snps_pkg::ROOT_W-1:0]  root_o,
	output logic [snps_pkg::SQREM_W-1:0] rem_o
);

	logic [snps_pkg::SQREM_W+1:0] wide;
	logic [snps_pkg::SQREM_W+1:0] trial;
	logic [snps_pkg::SQREM_W+1:0] diff;
	logic                         ge;
	logic                         valid_s1;
	logic [TAG_BITS-1:0]          tag_s1;
	logic [snps_pkg::COORD_W-1:0] nx_s1;
	logic [snps_pkg::COORD_W-1:0] ny_s1;
	logic [snps_pkg::RAD_W-1:0]   rad_s1;
	logic [snps_pkg::ROOT_W-1:0]  root_s1;
	logic [snps_pkg::SQREM_W-1:0] rem_s1;

	always_comb begin
		wide  = {rem_i, rad_i[snps_pkg::RAD_W-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		diff  = wide - trial;
		ge    = (wide >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= tag_i;
			nx_s1   <= nx_i;
			ny_s1   <= ny_i;
			rad_s1  <= {rad_i[snps_pkg::RAD_W-3:0], 2'b00};
			root_s1 <= {root_i[snps_pkg::ROOT_W-2:0], ge};
			rem_s1  <= ge ? diff[snps_pkg::SQREM_W-1:0] : wide[snps_pkg::SQREM_W-1:0];
		end
	end

	assign valid_o = valid_s1;
	assign tag_o   = tag_s1;
	assign nx_o    = nx_s1;
	assign ny_o    = ny_s1;
	assign rad_o   = rad_s1;
	assign root_o  = root_s1;
	assign rem_o   = rem_s1;

endmodule

@@ rtl/core/segment_nearest_point_snap_core.sv @@
// Segment nearest point snap core: projects the cursor onto each segment word.
// Stages: setup, restoring divider, lerp and distance, square root, output.
// Emits only words within the tolerance; one word per cycle unless stalled.
// The whole pipeline holds while the output word is stalled.
// Reset clears all valid bits, the output valid and the cursor and tolerance.
module segment_nearest_point_snap_core #(
	parameter int TAG_BITS    = 8,
	parameter int T_FRAC_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  snps_pkg::snps_idx_t          cfg_index,
	input  logic [snps_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [snps_pkg::COORD_W-1:0] start_x,
	input  logic [snps_pkg::COORD_W-1:0] start_y,
	input  logic [snps_pkg::COORD_W-1:0] end_x,
	input  logic [snps_pkg::COORD_W-1:0] end_y,
	input  logic [TAG_BITS-1:0]          segment_tag,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [snps_pkg::COORD_W-1:0] snap_x,
	output logic [snps_pkg::COORD_W-1:0] snap_y,
	output logic [snps_pkg::DIST_W-1:0]  snap_distance,
	output logic [TAG_BITS-1:0]          result_tag
);

	localparam int LP_W = T_FRAC_BITS + snps_pkg::DIFF_W + 1;

	logic                          adv;
	logic [snps_pkg::COORD_W-1:0]  cursor_x_q;
	logic [snps_pkg::COORD_W-1:0]  cursor_y_q;
	logic [snps_pkg::TOL_W-1:0]    tol_q;

	logic                          v_s1;
	logic [TAG_BITS-1:0]           tag_s1;
	snps_pkg::snps_seg_t           seg_s1;
	logic [snps_pkg::DIFF_W-1:0]   rx_s1;
	logic [snps_pkg::DIFF_W-1:0]   ry_s1;

	logic                          v_s2;
	logic [TAG_BITS-1:0]           tag_s2;
	snps_pkg::snps_seg_t           seg_s2;
	logic                          zero_s2;
	logic signed [snps_pkg::PROD_W-1:0] dxx_s2;
	logic signed [snps_pkg::PROD_W-1:0] dyy_s2;
	logic signed [snps_pkg::PROD_W-1:0] rdx_s2;
	logic signed [snps_pkg::PROD_W-1:0] rdy_s2;

	logic [snps_pkg::PROD_W-1:0]   len2_c;
	logic signed [snps_pkg::DOT_W-1:0] dot_c;
	snps_pkg::snps_mode_t          mode_c;

	logic                          v_s3;
	logic [TAG_BITS-1:0]           tag_s3;
	snps_pkg::snps_seg_t           seg_s3;
	logic [snps_pkg::PROD_W-1:0]   rem_s3;
	logic [snps_pkg::PROD_W-1:0]   len2_s3;

	logic                          dv    [T_FRAC_BITS+1];
	logic [TAG_BITS-1:0]           dtag  [T_FRAC_BITS+1];
	snps_pkg::snps_seg_t           dseg  [T_FRAC_BITS+1];
	logic [snps_pkg::PROD_W-1:0]   drem  [T_FRAC_BITS+1];
	logic [snps_pkg::PROD_W-1:0]   dlen2 [T_FRAC_BITS+1];
	logic [T_FRAC_BITS-1:0]        dt    [T_FRAC_BITS+1];

	logic                          v_s4;
	logic [TAG_BITS-1:0]           tag_s4;
	snps_pkg::snps_seg_t           seg_s4;
	logic signed [LP_W-1:0]        px_s4;
	logic signed [LP_W-1:0]        py_s4;
	logic signed [LP_W-1:0]        offx_c;
	logic signed [LP_W-1:0]        offy_c;
	logic [snps_pkg::COORD_W-1:0]  nx_c;
	logic [snps_pkg::COORD_W-1:0]  ny_c;

	logic                          v_s5;
	logic [TAG_BITS-1:0]           tag_s5;
	logic [snps_pkg::COORD_W-1:0]  nx_s5;
	logic [snps_pkg::COORD_W-1:0]  ny_s5;

	logic                          v_s6;
	logic [TAG_BITS-1:0]           tag_s6;
	logic [snps_pkg::COORD_W-1:0]  nx_s6;
	logic [snps_pkg::COORD_W-1:0]  ny_s6;
	logic [snps_pkg::DIFF_W-1:0]   ox_s6;
	logic [snps_pkg::DIFF_W-1:0]   oy_s6;

	logic                          v_s7;
	logic [TAG_BITS-1:0]           tag_s7;
	logic [snps_pkg::COORD_W-1:0]  nx_s7;
	logic [snps_pkg::COORD_W-1:0]  ny_s7;
	logic signed [snps_pkg::PROD_W-1:0] oxx_s7;
	logic signed [snps_pkg::PROD_W-1:0] oyy_s7;
	logic [snps_pkg::TOL2_W-1:0]   tol2_s7;
	logic [snps_pkg::PROD_W-1:0]   d2_c;

	logic                          v_s8;
	logic [TAG_BITS-1:0]           tag_s8;
	logic [snps_pkg::COORD_W-1:0]  nx_s8;
	logic [snps_pkg::COORD_W-1:0]  ny_s8;
	logic [snps_pkg::PROD_W-1:0]   d2_s8;

	logic                          qv    [snps_pkg::ROOT_W+1];
	logic [TAG_BITS-1:0]           qtag  [snps_pkg::ROOT_W+1];
	logic [snps_pkg::COORD_W-1:0]  qnx   [snps_pkg::ROOT_W+1];
	logic [snps_pkg::COORD_W-1:0]  qny   [snps_pkg::ROOT_W+1];
	logic [snps_pkg::RAD_W-1:0]    qrad  [snps_pkg::ROOT_W+1];
	logic [snps_pkg::ROOT_W-1:0]   qroot [snps_pkg::ROOT_W+1];
	logic [snps_pkg::SQREM_W-1:0]  qrem  [snps_pkg::ROOT_W+1];

	logic                          out_valid_q;
	logic [snps_pkg::COORD_W-1:0]  snap_x_q;
	logic [snps_pkg::COORD_W-1:0]  snap_y_q;
	logic [snps_pkg::DIST_W-1:0]   snap_distance_q;
	logic [TAG_BITS-1:0]           result_tag_q;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			tol_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				snps_pkg::CFG_CURSOR_X:  cursor_x_q <= cfg_data;
				snps_pkg::CFG_CURSOR_Y:  cursor_y_q <= cfg_data;
				snps_pkg::CFG_TOLERANCE: tol_q      <= cfg_data[snps_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dv[T_FRAC_BITS];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			// drop words outside the tolerance
			v_s8 <= v_s7 && (d2_c <= {{(snps_pkg::PROD_W - snps_pkg::TOL2_W){1'b0}}, tol2_s7});
			out_valid_q <= qv[snps_pkg::ROOT_W];
		end
	end

	always_comb begin
		len2_c = dxx_s2[snps_pkg::PROD_W-1:0] + dyy_s2[snps_pkg::PROD_W-1:0];
		dot_c  = {rdx_s2[snps_pkg::PROD_W-1], rdx_s2} + {rdy_s2[snps_pkg::PROD_W-1], rdy_s2};
		if (zero_s2 || dot_c[snps_pkg::DOT_W-1] || dot_c == '0) begin
			mode_c = snps_pkg::MODE_START;
		end else if (dot_c[snps_pkg::PROD_W-1:0] >= len2_c) begin
			mode_c = snps_pkg::MODE_END;
		end else begin
			mode_c = snps_pkg::MODE_LERP;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1      <= segment_tag;
			seg_s1.sx   <= start_x;
			seg_s1.sy   <= start_y;
			seg_s1.ex   <= end_x;
			seg_s1.ey   <= end_y;
			seg_s1.dx   <= {end_x[31], end_x} - {start_x[31], start_x};
			seg_s1.dy   <= {end_y[31], end_y} - {start_y[31], start_y};
			seg_s1.mode <= snps_pkg::MODE_START;
			rx_s1       <= {cursor_x_q[31], cursor_x_q} - {start_x[31], start_x};
			ry_s1       <= {cursor_y_q[31], cursor_y_q} - {start_y[31], start_y};

			tag_s2  <= tag_s1;
			seg_s2  <= seg_s1;
			zero_s2 <= (seg_s1.dx == '0) && (seg_s1.dy == '0);
			dxx_s2  <= $signed(seg_s1.dx) * $signed(seg_s1.dx);
			dyy_s2  <= $signed(seg_s1.dy) * $signed(seg_s1.dy);
			rdx_s2  <= $signed(rx_s1) * $signed(seg_s1.dx);
			rdy_s2  <= $signed(ry_s1) * $signed(seg_s1.dy);

			tag_s3      <= tag_s2;
			seg_s3.sx   <= seg_s2.sx;
			seg_s3.sy   <= seg_s2.sy;
			seg_s3.ex   <= seg_s2.ex;
			seg_s3.ey   <= seg_s2.ey;
			seg_s3.dx   <= seg_s2.dx;
			seg_s3.dy   <= seg_s2.dy;
			seg_s3.mode <= mode_c;
			rem_s3      <= dot_c[snps_pkg::PROD_W-1:0];
			len2_s3     <= len2_c;
		end
	end

	assign dv[0]    = v_s3;
	assign dtag[0]  = tag_s3;
	assign dseg[0]  = seg_s3;
	assign drem[0]  = rem_s3;
	assign dlen2[0] = len2_s3;
	assign dt[0]    = '0;

	for (genvar i = 0; i < T_FRAC_BITS; i++) begin : g_div
		snps_div_stage #(
			.T_FRAC_BITS(T_FRAC_BITS),
			.TAG_BITS(TAG_BITS)
		) u_div (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.valid_i(dv[i]),
			.tag_i(dtag[i]),
			.seg_i(dseg[i]),
			.rem_i(drem[i]),
			.len2_i(dlen2[i]),
			.t_i(dt[i]),
			.valid_o(dv[i+1]),
			.tag_o(dtag[i+1]),
			.seg_o(dseg[i+1]),
			.rem_o(drem[i+1]),
			.len2_o(dlen2[i+1]),
			.t_o(dt[i+1])
		);
	end

	always_comb begin
		offx_c = px_s4 >>> T_FRAC_BITS;
		offy_c = py_s4 >>> T_FRAC_BITS;
		case (seg_s4.mode)
			snps_pkg::MODE_END: begin
				nx_c = seg_s4.ex;
				ny_c = seg_s4.ey;
			end
			snps_pkg::MODE_LERP: begin
				nx_c = seg_s4.sx + offx_c[snps_pkg::COORD_W-1:0];
				ny_c = seg_s4.sy + offy_c[snps_pkg::COORD_W-1:0];
			end
			default: begin
				nx_c = seg_s4.sx;
				ny_c = seg_s4.sy;
			end
		endcase
		d2_c = oxx_s7[snps_pkg::PROD_W-1:0] + oyy_s7[snps_pkg::PROD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s4 <= dtag[T_FRAC_BITS];
			seg_s4 <= dseg[T_FRAC_BITS];
			px_s4  <= $signed({1'b0, dt[T_FRAC_BITS]}) * $signed(dseg[T_FRAC_BITS].dx);
			py_s4  <= $signed({1'b0, dt[T_FRAC_BITS]}) * $signed(dseg[T_FRAC_BITS].dy);

			tag_s5 <= tag_s4;
			nx_s5  <= nx_c;
			ny_s5  <= ny_c;

			tag_s6 <= tag_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
			ox_s6  <= {cursor_x_q[31], cursor_x_q} - {nx_s5[31], nx_s5};
			oy_s6  <= {cursor_y_q[31], cursor_y_q} - {ny_s5[31], ny_s5};

			tag_s7  <= tag_s6;
			nx_s7   <= nx_s6;
			ny_s7   <= ny_s6;
			oxx_s7  <= $signed(ox_s6) * $signed(ox_s6);
			oyy_s7  <= $signed(oy_s6) * $signed(oy_s6);
			tol2_s7 <= tol_q * tol_q;

			tag_s8 <= tag_s7;
			nx_s8  <= nx_s7;
			ny_s8  <= ny_s7;
			d2_s8  <= d2_c;
		end
	end

	assign qv[0]    = v_s8;
	assign qtag[0]  = tag_s8;
	assign qnx[0]   = nx_s8;
	assign qny[0]   = ny_s8;
	assign qrad[0]  = {{(snps_pkg::RAD_W - snps_pkg::PROD_W){1'b0}}, d2_s8};
	assign qroot[0] = '0;
	assign qrem[0]  = '0;

	for (genvar j = 0; j < snps_pkg::ROOT_W; j++) begin : g_sqrt
		snps_sqrt_stage #(
			.TAG_BITS(TAG_BITS)
		) u_sqrt (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.valid_i(qv[j]),
			.tag_i(qtag[j]),
			.nx_i(qnx[j]),
			.ny_i(qny[j]),
			.rad_i(qrad[j]),
			.root_i(qroot[j]),
			.rem_i(qrem[j]),
			.valid_o(qv[j+1]),
			.tag_o(qtag[j+1]),
			.nx_o(qnx[j+1]),
			.ny_o(qny[j+1]),
			.rad_o(qrad[j+1]),
			.root_o(qroot[j+1]),
			.rem_o(qrem[j+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			snap_x_q        <= qnx[snps_pkg::ROOT_W];
			snap_y_q        <= qny[snps_pkg::ROOT_W];
			snap_distance_q <= qroot[snps_pkg::ROOT_W][snps_pkg::DIST_W-1:0];
			result_tag_q    <= qtag[snps_pkg::ROOT_W];
		end
	end

	assign out_valid     = out_valid_q;
	assign snap_x        = snap_x_q;
	assign snap_y        = snap_y_q;
	assign snap_distance = snap_distance_q;
	assign result_tag    = result_tag_q;

	a_lerp_rem_below_len2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && seg_s3.mode == snps_pkg::MODE_LERP) |-> (rem_s3 < len2_s3))
		else $error("divider operand not below squared length");

	a_distance_within_tol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (snap_distance_q <= {2'b00, tol_q}))
		else $error("emitted distance exceeds tolerance");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s8) && $stable(v_s1)))
		else $error("pipeline moved while output stalled");

endmodule

@@ tb/segment_nearest_point_snap_core_tb.sv @@
// Self-checking testbench for segment_nearest_point_snap_core: directed and random
// segment words, cursor and tolerance settings, and random idling on both sides.
// Depends on snps_pkg and the core; predicts each result in 128-bit integer math.
module segment_nearest_point_snap_core_tb;

	localparam snps_pkg::snps_idx_t CFG_UNUSED = 2'd3;
	localparam int                  LATENCY    = 32 + 45;

	typedef struct {
		logic [snps_pkg::COORD_W-1:0] sx, sy, ex, ey;
		logic [7:0]                   tag;
	} segment_t;

	typedef struct {
		logic [snps_pkg::COORD_W-1:0] x, y;
		logic [snps_pkg::DIST_W-1:0]  distance;
		logic [7:0]                   tag;
	} snap_t;

	logic                         clk = 0;
	logic                         arst_n = 0;
	logic                         cfg_we = 0;
	snps_pkg::snps_idx_t          cfg_index = snps_pkg::CFG_CURSOR_X;
	logic [snps_pkg::CFG_W-1:0]   cfg_data = '0;
	logic                         in_valid = 0;
	logic                         in_stall;
	logic [snps_pkg::COORD_W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic [7:0]                   segment_tag = '0;
	logic                         out_valid;
	logic                         out_stall = 0;
	logic [snps_pkg::COORD_W-1:0] snap_x, snap_y;
	logic [snps_pkg::DIST_W-1:0]  snap_distance;
	logic [7:0]                   result_tag;

	segment_nearest_point_snap_core dut (.*);

	segment_t segments_to_send[$];
	snap_t    snaps_due[$];
	logic [snps_pkg::COORD_W-1:0] cur_x = '0, cur_y = '0;
	logic [snps_pkg::TOL_W-1:0]   cur_tol = '0;
	int  send_idle_pct = 0, stall_pct = 0;
	int  hold_reqs = 0, hold_served = 0, hold_left = 0;
	int  mismatches = 0;
	bit  taken = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic logic [127:0] floor_sqrt(logic [127:0] v);
		logic [127:0] r, c;
		r = 0;
		for (int b = snps_pkg::ROOT_W - 1; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= v) r = c;
		end
		return r;
	endfunction

	function automatic bit predict_snap(segment_t s, output snap_t r);
		logic signed [127:0] sx, sy, ex, ey, px, py, dx, dy, len2, dot, t;
		logic signed [127:0] nx, ny, ox, oy, d2, tol2;
		logic [127:0]        root;
		sx = $signed(s.sx); sy = $signed(s.sy);
		ex = $signed(s.ex); ey = $signed(s.ey);
		px = $signed(cur_x); py = $signed(cur_y);
		dx = ex - sx; dy = ey - sy;
		len2 = dx * dx + dy * dy;
		dot = (px - sx) * dx + (py - sy) * dy;
		if (len2 == 0 || dot <= 0) begin
			nx = sx; ny = sy;
		end else if (dot >= len2) begin
			nx = ex; ny = ey;
		end else begin
			t = (dot <<< 32) / len2;
			nx = sx + ((t * dx) >>> 32);
			ny = sy + ((t * dy) >>> 32);
		end
		ox = px - nx; oy = py - ny;
		d2 = ox * ox + oy * oy;
		tol2 = {97'b0, cur_tol};
		tol2 = tol2 * tol2;
		r.x = nx[31:0]; r.y = ny[31:0];
		root = floor_sqrt(d2);
		r.distance = root[snps_pkg::DIST_W-1:0];
		r.tag = s.tag;
		return d2 <= tol2;
	endfunction

	always @(posedge clk) begin
		snap_t r, e;
		taken <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			if (predict_snap('{start_x, start_y, end_x, end_y, segment_tag}, r))
				snaps_due.push_back(r);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (snaps_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected snap x=%h y=%h dist=%h tag=%h",
						snap_x, snap_y, snap_distance, result_tag);
			end else begin
				e = snaps_due.pop_front();
				if (snap_x !== e.x || snap_y !== e.y || snap_distance !== e.distance ||
						result_tag !== e.tag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("snap mismatch: exp x=%h y=%h dist=%h tag=%h, got %h %h %h %h",
							e.x, e.y, e.distance, e.tag, snap_x, snap_y, snap_distance,
							result_tag);
				end
			end
		end
	end

	always @(negedge clk) begin
		segment_t s;
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || taken) begin
			if (segments_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s = segments_to_send.pop_front();
				start_x <= s.sx; start_y <= s.sy;
				end_x <= s.ex; end_y <= s.ey;
				segment_tag <= s.tag;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else if (hold_served < hold_reqs) begin
			hold_served <= hold_served + 1;
			hold_left <= 300;
			out_stall <= 1;
		end else begin
			out_stall <= $urandom_range(99) < stall_pct;
		end
	end

	task automatic write_reg(snps_pkg::snps_idx_t idx, logic [snps_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we = 1; cfg_index = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			snps_pkg::CFG_CURSOR_X:  cur_x = val;
			snps_pkg::CFG_CURSOR_Y:  cur_y = val;
			snps_pkg::CFG_TOLERANCE: cur_tol = val[snps_pkg::TOL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (segments_to_send.size() == 0 && !in_valid);
		wait (snaps_due.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	task automatic add_seg(int sx, int sy, int ex, int ey, int tag);
		segments_to_send.push_back('{sx, sy, ex, ey, tag[7:0]});
	endtask

	function automatic logic [31:0] near_coord(logic [31:0] base);
		if ($urandom_range(3) == 0) return $urandom;
		return base + $urandom_range(4000) - 2000;
	endfunction

	initial begin
		segment_t s;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		add_seg(0, 0, 0, 0, 0);
		add_seg(-256, 0, 256, 0, 255);
		add_seg(256, 256, 512, 512, 1);
		drain();

		write_reg(snps_pkg::CFG_TOLERANCE, 32'h7fffffff);
		add_seg(256, 0, 512, 0, 2);
		add_seg(-512, 0, -256, 0, 3);
		add_seg(300, 100, -700, -333, 4);
		add_seg(-1000, 77, 3, -905, 5);
		add_seg(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 6);
		add_seg(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 7);
		add_seg(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 8);
		add_seg(32'h80000000, 0, 32'h7fffffff, 0, 9);
		drain();

		write_reg(CFG_UNUSED, 32'h12345678);
		write_reg(snps_pkg::CFG_CURSOR_X, 32'h80000000);
		write_reg(snps_pkg::CFG_CURSOR_Y, 32'h7fffffff);
		add_seg(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 10);
		add_seg(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 11);
		add_seg(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 12);
		add_seg(0, 0, 32'h80000000, 32'h7fffff00, 13);
		drain();

		write_reg(snps_pkg::CFG_CURSOR_X, 0);
		write_reg(snps_pkg::CFG_CURSOR_Y, 0);
		write_reg(snps_pkg::CFG_TOLERANCE, 1000);
		add_seg(-5000, 1000, 5000, 1000, 14);
		add_seg(-5000, 1001, 5000, 1001, 15);
		add_seg(1000, -5000, 1000, 5000, 16);
		add_seg(-600, 800, -600, 800, 17);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 85; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 85; end
				default: begin send_idle_pct = 17; stall_pct = 17; end
			endcase
			write_reg(snps_pkg::CFG_CURSOR_X, (ph == 7) ? 32'h7fffffff : $urandom);
			write_reg(snps_pkg::CFG_CURSOR_Y, (ph == 7) ? 32'h80000000 : $urandom);
			write_reg(snps_pkg::CFG_TOLERANCE, (ph % 2) ? $urandom_range(8000) : $urandom);
			if (ph == 0) hold_reqs++;
			for (int i = 0; i < 68; i++) begin
				s.sx = near_coord(cur_x); s.sy = near_coord(cur_y);
				s.ex = near_coord(cur_x); s.ey = near_coord(cur_y);
				if ($urandom_range(15) == 0) begin
					s.ex = s.sx; s.ey = s.sy;
				end
				s.tag = 8'($urandom);
				segments_to_send.push_back(s);
			end
			drain();
		end

		if (mismatches == 0)
			$display("segment_nearest_point_snap_core_tb OK");
		else
			$display("segment_nearest_point_snap_core_tb NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("segment_nearest_point_snap_core_tb NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/snps_pkg.sv
rtl/core/snps_div_stage.sv
rtl/core/snps_sqrt_stage.sv
rtl/core/segment_nearest_point_snap_core.sv
tb/segment_nearest_point_snap_core_tb.sv
